### sv/ldf_pkg.sv
// types and constants shared by the sentence deframer modules
`timescale 1ns / 1ps

package ldf_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W = 16;
	localparam int LEN_W = 32;
	localparam int PFX_W = 3;
	localparam int KIND_W = 2;
	localparam int OUT_DATA_W = BYTE_W + IDX_W;

	localparam logic [IDX_W-1:0] MAX_WORDS_RST = 16'd1024;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_PREFIX,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		K_PAYLOAD,
		K_END,
		K_BADPFX,
		K_TOOMANY
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		kind_t kind;
		logic last;
		logic [IDX_W-1:0] index;
	} result_t;

endpackage

### sv/length_prefixed_sentence_deframer.sv
// length-prefixed sentence deframer: top level
//
// bytes of a received stream enter on the s_ group, one per transfer. each
// word opens with a 1 to 5 byte length prefix; payload bytes leave on the
// m_ group tagged with the word index, tlast on the final byte of a word.
// tuser gives the kind: payload, sentence end (zero length), bad lead byte,
// or too many words for max_words. prefix bytes give no payload transfer,
// only control results. max_words is loaded through cfg_we / cfg_wdata;
// the user must do so only while the block is idle, as the block does not
// enforce it. a result passes the input register, then the result
// register, where it waits. one byte per cycle while the receiver does not
// stall; decode is combinational, all counters update as a byte moves on.
// when the receiver stalls, the result register holds and the input
// register keeps taking bytes until one that gives a result waits in it;
// s_tready then drops until m_tready.
// reset clears both stages, sets max_words to 1024 and waits for a lead
// byte of a new sentence with the word count at zero.
`timescale 1ns / 1ps

module length_prefixed_sentence_deframer
	import ldf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // in_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // out_byte, word_index
	output logic [KIND_W-1:0]     m_tuser,   // kind
	output logic                  m_tlast    // last_in_word
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              res_valid;
	result_t           res;
	logic              out_ready;
	logic [IDX_W-1:0]  max_words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_words_q <= MAX_WORDS_RST;
		end else if (cfg_we) begin
			max_words_q <= cfg_wdata;
		end
	end

	// a byte moves on unless its result has nowhere to go
	assign advance = valid_s1 && (!res_valid || out_ready);

	ldf_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	ldf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.step      (advance),
		.max_words (max_words_q),
		.res_valid (res_valid),
		.res       (res)
	);

	ldf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_ctrl_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != K_PAYLOAD) |-> (m_tdata == '0 && !m_tlast))
		else $error("control result carries payload fields");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte lost");

	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

### sv/ldf_in_reg.sv
// input register stage holding one received byte
`timescale 1ns / 1ps

module ldf_in_reg
	import ldf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  logic              advance,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

### sv/ldf_core.sv
// prefix decoder, payload counter and word counter
`timescale 1ns / 1ps

module ldf_core
	import ldf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic              step,
	input  logic [IDX_W-1:0]  max_words,
	output logic              res_valid,
	output result_t           res
);

	phase_t            phase_q, phase_d;
	logic [PFX_W-1:0]  pfx_left_q, pfx_left_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  pay_left_q, pay_left_d;
	logic [IDX_W-1:0]  word_cnt_q, word_cnt_d;

	logic [LEN_W-1:0]  prefix_acc;
	logic [PFX_W-1:0]  pfx_dec;
	logic              lead_short;
	logic              lead_bad;
	logic [LEN_W-1:0]  lead_len;
	logic [PFX_W-1:0]  lead_cnt;
	logic [LEN_W-1:0]  done_len;
	logic              len_zero;
	logic              too_many;
	logic              pay_last;

	// length decode
	always_comb begin
		prefix_acc = {len_q[LEN_W-BYTE_W-1:0], byte_s1};
		pfx_dec = pfx_left_q - PFX_W'(pfx_left_q != '0);
		lead_short = !byte_s1[7];
		lead_bad = 1'b0;
		lead_len = '0;
		lead_cnt = '0;
		if (byte_s1[7:6] == 2'b10) begin
			lead_len = LEN_W'(byte_s1[5:0]);
			lead_cnt = 3'd1;
		end else if (byte_s1[7:5] == 3'b110) begin
			lead_len = LEN_W'(byte_s1[4:0]);
			lead_cnt = 3'd2;
		end else if (byte_s1[7:4] == 4'b1110) begin
			lead_len = LEN_W'(byte_s1[3:0]);
			lead_cnt = 3'd3;
		end else if (byte_s1 == 8'hF0) begin
			lead_cnt = 3'd4;
		end else if (!lead_short) begin
			lead_bad = 1'b1;
		end
		done_len = (phase_q == PH_PREFIX) ? prefix_acc : LEN_W'(byte_s1[6:0]);
		len_zero = (done_len == '0);
		too_many = (word_cnt_q >= max_words);
		pay_last = (pay_left_q <= LEN_W'(1));
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_PAYLOAD: begin
				phase_d = pay_last ? PH_LEAD : PH_PAYLOAD;
			end
			PH_PREFIX: begin
				if (pfx_dec != '0) begin
					phase_d = PH_PREFIX;
				end else if (len_zero || too_many) begin
					phase_d = PH_LEAD;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			default: begin
				if (lead_short) begin
					phase_d = (len_zero || too_many) ? PH_LEAD : PH_PAYLOAD;
				end else if (lead_bad) begin
					phase_d = PH_LEAD;
				end else begin
					phase_d = PH_PREFIX;
				end
			end
		endcase
	end

	// results and counters
	always_comb begin
		res_valid = 1'b0;
		res = '{data: '0, kind: K_PAYLOAD, last: 1'b0, index: '0};
		pfx_left_d = pfx_left_q;
		len_d = len_q;
		pay_left_d = pay_left_q;
		word_cnt_d = word_cnt_q;
		case (phase_q)
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				res.data = byte_s1;
				res.last = pay_last;
				res.index = word_cnt_q;
				if (pay_last) begin
					pay_left_d = '0;
					word_cnt_d = word_cnt_q + 16'd1;
				end else begin
					pay_left_d = pay_left_q - 32'd1;
				end
			end
			PH_PREFIX: begin
				if (pfx_dec != '0) begin
					pfx_left_d = pfx_dec;
					len_d = prefix_acc;
				end else begin
					pfx_left_d = '0;
					len_d = '0;
					if (len_zero || too_many) begin
						res_valid = 1'b1;
						res.kind = len_zero ? K_END : K_TOOMANY;
						pay_left_d = '0;
						word_cnt_d = '0;
					end else begin
						pay_left_d = done_len;
					end
				end
			end
			default: begin
				if (lead_short) begin
					pfx_left_d = '0;
					len_d = '0;
					if (len_zero || too_many) begin
						res_valid = 1'b1;
						res.kind = len_zero ? K_END : K_TOOMANY;
						pay_left_d = '0;
						word_cnt_d = '0;
					end else begin
						pay_left_d = done_len;
					end
				end else if (lead_bad) begin
					res_valid = 1'b1;
					res.kind = K_BADPFX;
					pfx_left_d = '0;
					len_d = '0;
					pay_left_d = '0;
					word_cnt_d = '0;
				end else begin
					pfx_left_d = lead_cnt;
					len_d = lead_len;
				end
			end
		endcase
		if (!valid_s1) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pfx_left_q <= '0;
			len_q <= '0;
			pay_left_q <= '0;
			word_cnt_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pfx_left_q <= pfx_left_d;
			len_q <= len_d;
			pay_left_q <= pay_left_d;
			word_cnt_q <= word_cnt_d;
		end
	end

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pay_left_q != '0)
		else $error("payload phase with nothing left to count");

	a_prefix_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PREFIX |-> (pfx_left_q != '0 && pfx_left_q <= 3'd4))
		else $error("prefix phase with bad byte count");

	a_accum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_PREFIX |-> len_q == '0)
		else $error("length accumulator not cleared outside prefix");

endmodule

### sv/ldf_out_reg.sv
// result register on the master side
`timescale 1ns / 1ps

module ldf_out_reg
	import ldf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  result_t               res,
	output logic                  out_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [KIND_W-1:0]     m_tuser,
	output logic                  m_tlast
);

	assign out_ready = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_ready) begin
			m_tdata <= {res.index, res.data};
			m_tuser <= res.kind;
			m_tlast <= res.last;
		end
	end

endmodule
